// File: design/usart_mode_command_rx_fifo_defines.svh
// ---------------------------------------------------------------------------
// USART mode/command receive FIFO: assertion macros
// Shared assertion forms for the checker of the receive block.
// ---------------------------------------------------------------------------
`ifndef USART_MODE_COMMAND_RX_FIFO_DEFINES_SVH
`define USART_MODE_COMMAND_RX_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define USMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usmc assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define USMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usmc assertion failed");

`endif

// File: design/usmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// USART mode/command receive FIFO: package
// Operation and mode codes, status layout and the structs between modules.
// ---------------------------------------------------------------------------
package usmc_pkg;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_RECV  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		MSEQ_IDLE    = 3'd0,
		MSEQ_SYNC    = 3'd1,
		MSEQ_ASYNC   = 3'd2,
		MSEQ_SYNC_C1 = 3'd3,
		MSEQ_SYNC_C2 = 3'd4
	} mode_t;

	localparam logic [1:0]  MODE_BAUD_MASK = 2'h3;
	localparam int          CMD_TXEN_BIT   = 0;
	localparam int          CMD_RXEN_BIT   = 2;
	localparam int          CMD_IRESET_BIT = 6;
	localparam logic [7:0]  ST_TXRDY       = 8'h01;
	localparam logic [7:0]  ST_RXRDY       = 8'h02;
	localparam logic [7:0]  ST_TXE         = 8'h04;
	localparam logic [7:0]  HOLD_RESET     = 8'hff;
	localparam logic [15:0] DELAY_RESET    = 16'd100;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic [7:0] wdata;
	} fifo_req_t;

	typedef struct packed {
		logic       empty;
		logic       one;
		logic [7:0] head;
	} fifo_stat_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_data;
		logic       rxrdy_level;
		logic       rxrdy_notify;
	} result_t;

endpackage

// File: design/usmc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module usmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/usmc_rx_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Receive FIFO
// Circular buffer in RAM that always presents the word at its head.
// ---------------------------------------------------------------------------
module usmc_rx_fifo #(
	parameter int DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  usmc_pkg::fifo_req_t   req,
	output usmc_pkg::fifo_stat_t  stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q, tail_q, head_d;
	logic [CW-1:0] count_q;
	logic          full, we;
	logic          byp_sel_q;
	logic [7:0]    byp_q, rdata;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign we   = req.push && !full;

	always_comb begin
		if (req.clr) begin
			head_d = '0;
		end else if (req.pop) begin
			head_d = ptr_inc(head_q);
		end else begin
			head_d = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			byp_sel_q <= 1'b0;
		end else begin
			head_q    <= head_d;
			byp_sel_q <= we && (tail_q == head_d);
			if (req.clr) begin
				tail_q  <= '0;
				count_q <= '0;
			end else if (we) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end else if (req.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// A word written to the entry being fetched arrives through the bypass.
	always_ff @(posedge clk) begin
		byp_q <= req.wdata;
	end

	usmc_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (req.wdata),
		.raddr (head_d),
		.rdata (rdata)
	);

	assign stat.empty = (count_q == '0);
	assign stat.one   = (count_q == CW'(1));
	assign stat.head  = byp_sel_q ? byp_q : rdata;

endmodule

// File: design/usmc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// USART control
// Mode sequence, commands, receive timer, holding register and results.
// ---------------------------------------------------------------------------
module usmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [2:0]           operation,
	input  logic                 port_select,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           byte_mask,
	input  logic [15:0]          delay,
	input  usmc_pkg::fifo_stat_t fstat,
	output usmc_pkg::fifo_req_t  freq,
	output usmc_pkg::result_t    res
);

	usmc_pkg::mode_t mode_q, mode_d;
	logic            te_q, te_d, re_q, re_d, rxrdy_q, rxrdy_d, pend_q, pend_d;
	logic [7:0]      hold_q, hold_d;
	logic [15:0]     cnt_q, cnt_d, cnt_dec, start_val;
	logic            left;

	assign start_val = (delay == '0) ? 16'd1 : delay;

	always_comb begin
		mode_d  = mode_q;
		te_d    = te_q;
		re_d    = re_q;
		rxrdy_d = rxrdy_q;
		pend_d  = pend_q;
		hold_d  = hold_q;
		cnt_d   = cnt_q;
		cnt_dec = cnt_q;
		left    = 1'b0;
		freq    = '0;
		res     = '0;
		freq.wdata = data_byte & byte_mask;
		if (go) begin
			case (operation)
				usmc_pkg::OP_WRITE: begin
					if (port_select) begin
						case (mode_q)
							usmc_pkg::MSEQ_IDLE: begin
								mode_d = ((data_byte[1:0] & usmc_pkg::MODE_BAUD_MASK) != '0) ?
									usmc_pkg::MSEQ_ASYNC : usmc_pkg::MSEQ_SYNC_C1;
							end
							usmc_pkg::MSEQ_SYNC_C1: mode_d = usmc_pkg::MSEQ_SYNC_C2;
							usmc_pkg::MSEQ_SYNC_C2: mode_d = usmc_pkg::MSEQ_SYNC;
							usmc_pkg::MSEQ_ASYNC, usmc_pkg::MSEQ_SYNC: begin
								if (data_byte[usmc_pkg::CMD_IRESET_BIT]) begin
									mode_d = usmc_pkg::MSEQ_IDLE;
								end else begin
									te_d = data_byte[usmc_pkg::CMD_TXEN_BIT];
									re_d = data_byte[usmc_pkg::CMD_RXEN_BIT];
									if (re_d && !fstat.empty && !pend_q) begin
										cnt_d  = start_val;
										pend_d = 1'b1;
									end
								end
							end
							default: ;
						endcase
					end else if (te_q) begin
						res.tx_valid = 1'b1;
						res.tx_data  = data_byte;
					end
				end
				usmc_pkg::OP_READ: begin
					if (port_select) begin
						res.read_data = usmc_pkg::ST_TXRDY | usmc_pkg::ST_TXE |
							(rxrdy_q ? usmc_pkg::ST_RXRDY : 8'h00);
					end else begin
						if (rxrdy_q) begin
							rxrdy_d          = 1'b0;
							res.rxrdy_notify = 1'b1;
						end
						res.read_data = hold_q;
					end
				end
				usmc_pkg::OP_RECV: begin
					freq.push = 1'b1;
					if (re_q && !pend_q) begin
						cnt_d  = start_val;
						pend_d = 1'b1;
					end
				end
				usmc_pkg::OP_CLEAR: begin
					freq.clr = 1'b1;
				end
				usmc_pkg::OP_TICK: begin
					if (pend_q) begin
						cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
						cnt_d   = cnt_dec;
						if (cnt_dec == '0) begin
							left = !fstat.empty;
							if (re_q && !rxrdy_q) begin
								if (!fstat.empty) begin
									freq.pop = 1'b1;
									hold_d   = fstat.head;
									left     = !fstat.one;
								end
								rxrdy_d          = 1'b1;
								res.rxrdy_notify = 1'b1;
							end
							if (re_q && left) begin
								cnt_d = start_val;
							end else begin
								pend_d = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
		res.rxrdy_level = rxrdy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= usmc_pkg::MSEQ_IDLE;
			te_q    <= 1'b0;
			re_q    <= 1'b0;
			rxrdy_q <= 1'b0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
			hold_q  <= usmc_pkg::HOLD_RESET;
		end else begin
			mode_q  <= mode_d;
			te_q    <= te_d;
			re_q    <= re_d;
			rxrdy_q <= rxrdy_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
			hold_q  <= hold_d;
		end
	end

endmodule

// File: design/usart_mode_command_rx_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// USART mode/command register block with receive FIFO
// Bus accesses, received bytes and timer ticks in; one result word per item.
// ---------------------------------------------------------------------------
// The block takes one word every cycle while out_ready stays high, and
// presents its result word from a register: the word lands in an input
// register, and once the result register is free the control logic
// updates its state and loads the result register. A result word that
// waits at the output holds the input register, so the input stalls until
// the result is taken. The receive FIFO is a single RAM whose head word is
// fetched ahead from the next head pointer, with a bypass for a word written
// to the entry being fetched, which is what lets a timer expiry pop a byte
// without holding up the input. The FIFO store needs no clearing after reset.
module usart_mode_command_rx_fifo #(
	parameter int FIFO_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic        port_select,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  byte_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        tx_valid,
	output logic [7:0]  tx_data,
	output logic        rxrdy_level,
	output logic        rxrdy_notify,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                 valid_s1, adv;
	logic [2:0]           op_s1;
	logic                 port_s1;
	logic [7:0]           data_s1, mask_s1;
	logic [15:0]          delay_q;
	usmc_pkg::fifo_req_t  freq;
	usmc_pkg::fifo_stat_t fstat;
	usmc_pkg::result_t    res, res_q;
	logic                 out_valid_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			delay_q     <= usmc_pkg::DELAY_RESET;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			port_s1 <= port_select;
			data_s1 <= data_byte;
			mask_s1 <= byte_mask;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	usmc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (adv),
		.operation   (op_s1),
		.port_select (port_s1),
		.data_byte   (data_s1),
		.byte_mask   (mask_s1),
		.delay       (delay_q),
		.fstat       (fstat),
		.freq        (freq),
		.res         (res)
	);

	usmc_rx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (freq),
		.stat   (fstat)
	);

	assign out_valid    = out_valid_q;
	assign read_data    = res_q.read_data;
	assign tx_valid     = res_q.tx_valid;
	assign tx_data      = res_q.tx_data;
	assign rxrdy_level  = res_q.rxrdy_level;
	assign rxrdy_notify = res_q.rxrdy_notify;

endmodule

// File: design/usmc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// USART mode/command receive FIFO: port checker
// Checks result words against the rules of the block seen at its ports.
// ---------------------------------------------------------------------------
`include "usart_mode_command_rx_fifo_defines.svh"

module usmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic        tx_valid,
	input logic [7:0]  tx_data,
	input logic        rxrdy_level,
	input logic        rxrdy_notify
);

	logic last_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lvl_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_lvl_q <= rxrdy_level;
		end
	end

	// The ready flag only changes on a word that reports it.
	`USMC_ASSERT_NOW(a_level_change, out_valid && !rxrdy_notify, rxrdy_level == last_lvl_q)
	`USMC_ASSERT_NOW(a_tx_exclusive, out_valid && tx_valid, read_data == 8'h00 && !rxrdy_notify)
	`USMC_ASSERT_NOW(a_timer_word, out_valid && rxrdy_notify && rxrdy_level,
		read_data == 8'h00 && !tx_valid)
	`USMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(read_data) && $stable(tx_data) && $stable(rxrdy_level))

endmodule

bind usart_mode_command_rx_fifo usmc_checker u_usmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.tx_valid     (tx_valid),
	.tx_data      (tx_data),
	.rxrdy_level  (rxrdy_level),
	.rxrdy_notify (rxrdy_notify)
);

// File: verif/usart_mode_command_rx_fifo_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// USART mode/command receive FIFO: testbench
// Drives bus accesses, received bytes, FIFO clears and ticks through the
// valid/ready input, predicts every result word from a behavioral model of
// the mode sequencer, command register, receive FIFO and receive timer, and
// checks each result word field by field. Both sides pause at random, the
// receiver once holds off long enough to back the block up, and the receive
// delay register is stepped through several settings between phases.
// ---------------------------------------------------------------------------
module usart_mode_command_rx_fifo_tb;

	localparam int         FIFO_DEPTH     = 256;
	localparam int         GAP_PCT        = 19;
	localparam int         LONG_HOLD      = 150;
	localparam int         SETTLE_CYCLES  = 4;
	localparam int         OP_RSVD_LO     = 5;
	localparam int         OP_RSVD_HI     = 7;
	localparam int         CMD_ERESET_BIT = 4;
	localparam logic [7:0] ERR_BITS       = 8'h38;

	typedef struct packed {
		logic [2:0] op;
		logic       port;
		logic [7:0] data;
		logic [7:0] mask;
	} usart_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = usmc_pkg::OP_TICK;
	logic        port_select = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic [7:0]  byte_mask = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic        tx_valid;
	logic [7:0]  tx_data;
	logic        rxrdy_level;
	logic        rxrdy_notify;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	usart_word_t       pending_q[$];
	usmc_pkg::result_t expected_q[$];
	usart_word_t       cur_word;
	int                queued_total = 0;
	int                checked_total = 0;
	int                mismatches = 0;
	bit                no_gaps = 1'b0;
	bit                stall_armed = 1'b0;
	bit                stall_done = 1'b0;
	int                stall_left = 0;

	// Behavioral state of the block.
	logic [15:0]     rx_delay = usmc_pkg::DELAY_RESET;
	usmc_pkg::mode_t mode_now = usmc_pkg::MSEQ_IDLE;
	logic [7:0]      status_now = usmc_pkg::ST_TXRDY | usmc_pkg::ST_TXE;
	logic [7:0]      holding = usmc_pkg::HOLD_RESET;
	bit              tx_en = 1'b0;
	bit              rx_en = 1'b0;
	logic [7:0]      rx_store[FIFO_DEPTH];
	int              rx_head = 0;
	int              rx_tail = 0;
	int              rx_count = 0;
	bit              timer_armed = 1'b0;
	logic [15:0]     ticks_left = 16'd0;

	usart_mode_command_rx_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.port_select(port_select),
		.data_byte(data_byte),
		.byte_mask(byte_mask),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.tx_valid(tx_valid),
		.tx_data(tx_data),
		.rxrdy_level(rxrdy_level),
		.rxrdy_notify(rxrdy_notify),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void arm_timer();
		ticks_left = (rx_delay == 16'd0) ? 16'd1 : rx_delay;
		timer_armed = 1'b1;
	endfunction

	function automatic void arm_if_idle();
		if (rx_en && rx_count != 0 && !timer_armed)
			arm_timer();
	endfunction

	function automatic usmc_pkg::result_t predict_word(usart_word_t w);
		usmc_pkg::result_t r;
		r = '0;
		case (w.op)
			usmc_pkg::OP_WRITE: begin
				if (w.port) begin
					case (mode_now)
						usmc_pkg::MSEQ_IDLE: mode_now =
							((w.data[1:0] & usmc_pkg::MODE_BAUD_MASK) != 0) ?
							usmc_pkg::MSEQ_ASYNC : usmc_pkg::MSEQ_SYNC_C1;
						usmc_pkg::MSEQ_SYNC_C1: mode_now = usmc_pkg::MSEQ_SYNC_C2;
						usmc_pkg::MSEQ_SYNC_C2: mode_now = usmc_pkg::MSEQ_SYNC;
						usmc_pkg::MSEQ_ASYNC, usmc_pkg::MSEQ_SYNC: begin
							if (w.data[usmc_pkg::CMD_IRESET_BIT]) begin
								mode_now = usmc_pkg::MSEQ_IDLE;
							end else begin
								if (w.data[CMD_ERESET_BIT])
									status_now &= ~ERR_BITS;
								tx_en = w.data[usmc_pkg::CMD_TXEN_BIT];
								rx_en = w.data[usmc_pkg::CMD_RXEN_BIT];
								arm_if_idle();
							end
						end
						default: ;
					endcase
				end else if (tx_en) begin
					r.tx_valid = 1'b1;
					r.tx_data = w.data;
				end
			end
			usmc_pkg::OP_READ: begin
				if (w.port) begin
					r.read_data = status_now;
				end else begin
					if ((status_now & usmc_pkg::ST_RXRDY) != 0) begin
						status_now &= ~usmc_pkg::ST_RXRDY;
						r.rxrdy_notify = 1'b1;
					end
					r.read_data = holding;
				end
			end
			usmc_pkg::OP_RECV: begin
				if (rx_count < FIFO_DEPTH) begin
					rx_store[rx_tail] = w.data & w.mask;
					rx_tail = (rx_tail + 1) % FIFO_DEPTH;
					rx_count++;
				end
				arm_if_idle();
			end
			usmc_pkg::OP_CLEAR: begin
				rx_head = 0;
				rx_tail = 0;
				rx_count = 0;
			end
			usmc_pkg::OP_TICK: begin
				if (timer_armed) begin
					if (ticks_left != 16'd0)
						ticks_left--;
					if (ticks_left == 16'd0) begin
						if (rx_en && (status_now & usmc_pkg::ST_RXRDY) == 0) begin
							if (rx_count != 0) begin
								holding = rx_store[rx_head];
								rx_head = (rx_head + 1) % FIFO_DEPTH;
								rx_count--;
							end
							status_now |= usmc_pkg::ST_RXRDY;
							r.rxrdy_notify = 1'b1;
						end
						if (rx_en && rx_count != 0)
							arm_timer();
						else
							timer_armed = 1'b0;
					end
				end
			end
			default: ;
		endcase
		r.rxrdy_level = (status_now & usmc_pkg::ST_RXRDY) != 0;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_q.push_back(predict_word(cur_word));
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
					cur_word = pending_q.pop_front();
					in_valid <= 1'b1;
					operation <= cur_word.op;
					port_select <= cur_word.port;
					data_byte <= cur_word.data;
					byte_mask <= cur_word.mask;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		usmc_pkg::result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				checked_total++;
				if (expected_q.size() == 0) begin
					$error("Result word arrived with no expectation pending.");
					mismatches++;
				end else begin
					exp_r = expected_q.pop_front();
					if (read_data !== exp_r.read_data) begin
						$error("read_data: expected %0h, got %0h", exp_r.read_data, read_data);
						mismatches++;
					end
					if (tx_valid !== exp_r.tx_valid) begin
						$error("tx_valid: expected %0b, got %0b", exp_r.tx_valid, tx_valid);
						mismatches++;
					end
					if (tx_data !== exp_r.tx_data) begin
						$error("tx_data: expected %0h, got %0h", exp_r.tx_data, tx_data);
						mismatches++;
					end
					if (rxrdy_level !== exp_r.rxrdy_level) begin
						$error("rxrdy_level: expected %0b, got %0b", exp_r.rxrdy_level,
							rxrdy_level);
						mismatches++;
					end
					if (rxrdy_notify !== exp_r.rxrdy_notify) begin
						$error("rxrdy_notify: expected %0b, got %0b", exp_r.rxrdy_notify,
							rxrdy_notify);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stall_armed && !stall_done) begin
				stall_done = 1'b1;
				stall_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || $urandom_range(99) >= GAP_PCT;
			end
		end
	end

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(255));
	endfunction

	task automatic push_word(logic [2:0] op, logic port, logic [7:0] data, logic [7:0] mask);
		pending_q.push_back('{op, port, data, mask});
		queued_total++;
	endtask

	function automatic logic [7:0] rand_command();
		logic [7:0] c;
		c = rnd8();
		c[usmc_pkg::CMD_IRESET_BIT] = 1'b0;
		c[usmc_pkg::CMD_RXEN_BIT] = $urandom_range(99) < 85;
		return c;
	endfunction

	task automatic program_mode();
		logic [7:0] b;
		b = rnd8();
		if ($urandom_range(1))
			b[1:0] = b[1:0] & ~usmc_pkg::MODE_BAUD_MASK;
		push_word(usmc_pkg::OP_WRITE, 1'b1, b, rnd8());
		if ((b[1:0] & usmc_pkg::MODE_BAUD_MASK) == 0) begin
			push_word(usmc_pkg::OP_WRITE, 1'b1, rnd8(), rnd8());
			push_word(usmc_pkg::OP_WRITE, 1'b1, rnd8(), rnd8());
		end
	endtask

	// Only valid right after a drain, when mode_now is current.
	task automatic enter_command(logic [7:0] cmd);
		case (mode_now)
			usmc_pkg::MSEQ_IDLE: program_mode();
			usmc_pkg::MSEQ_SYNC_C1: begin
				push_word(usmc_pkg::OP_WRITE, 1'b1, rnd8(), rnd8());
				push_word(usmc_pkg::OP_WRITE, 1'b1, rnd8(), rnd8());
			end
			usmc_pkg::MSEQ_SYNC_C2: push_word(usmc_pkg::OP_WRITE, 1'b1, rnd8(), rnd8());
			default: ;
		endcase
		push_word(usmc_pkg::OP_WRITE, 1'b1, cmd, rnd8());
	endtask

	task automatic random_traffic(int n);
		int pick;
		logic [7:0] b;
		logic p;
		enter_command(rand_command());
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			b = rnd8();
			p = 1'($urandom_range(1));
			if (pick < 30) begin
				push_word(usmc_pkg::OP_RECV, p, b, ($urandom_range(99) < 70) ? 8'hff : rnd8());
			end else if (pick < 55) begin
				push_word(usmc_pkg::OP_TICK, p, b, rnd8());
			end else if (pick < 70) begin
				push_word(usmc_pkg::OP_READ, 1'b0, b, rnd8());
			end else if (pick < 78) begin
				push_word(usmc_pkg::OP_READ, 1'b1, b, rnd8());
			end else if (pick < 86) begin
				push_word(usmc_pkg::OP_WRITE, 1'b0, b, rnd8());
			end else if (pick < 92) begin
				push_word(usmc_pkg::OP_WRITE, 1'b1, rand_command(), rnd8());
			end else if (pick < 94) begin
				push_word(usmc_pkg::OP_CLEAR, p, b, rnd8());
			end else if (pick < 96) begin
				b[usmc_pkg::CMD_IRESET_BIT] = 1'b1;
				push_word(usmc_pkg::OP_WRITE, 1'b1, b, rnd8());
				program_mode();
				push_word(usmc_pkg::OP_WRITE, 1'b1, rand_command(), rnd8());
			end else if (pick < 98) begin
				push_word(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), p, b, rnd8());
			end else begin
				push_word(usmc_pkg::OP_WRITE, 1'b1, b, rnd8());
			end
		end
	endtask

	task automatic fill_receive_buffer();
		enter_command(8'h01);
		push_word(usmc_pkg::OP_CLEAR, 1'b0, rnd8(), rnd8());
		for (int i = 0; i < FIFO_DEPTH + 16; i++)
			push_word(usmc_pkg::OP_RECV, 1'($urandom_range(1)), rnd8(), rnd8());
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h05, rnd8());
		repeat (4)
			push_word(usmc_pkg::OP_TICK, 1'($urandom_range(1)), rnd8(), rnd8());
		push_word(usmc_pkg::OP_READ, 1'b1, rnd8(), rnd8());
		push_word(usmc_pkg::OP_READ, 1'b0, rnd8(), rnd8());
		push_word(usmc_pkg::OP_CLEAR, 1'b1, rnd8(), rnd8());
	endtask

	task automatic drain();
		while (checked_total < queued_total)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_rx_delay(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		rx_delay = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		set_rx_delay(16'd1);

		push_word(usmc_pkg::OP_READ, 1'b1, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_READ, 1'b0, 8'hff, 8'hff);
		push_word(usmc_pkg::OP_WRITE, 1'b0, 8'ha5, 8'h00);
		push_word(usmc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00);
		push_word(3'(OP_RSVD_HI), 1'b1, 8'hff, 8'hff);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'hff, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h15, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b0, 8'hff, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b0, 8'h00, 8'hff);
		push_word(usmc_pkg::OP_RECV, 1'b0, 8'hff, 8'h0f);
		push_word(usmc_pkg::OP_RECV, 1'b1, 8'haa, 8'hff);
		push_word(usmc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_TICK, 1'b1, 8'hff, 8'hff);
		push_word(usmc_pkg::OP_READ, 1'b1, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_READ, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_READ, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h40, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h02, 8'h00);
		push_word(usmc_pkg::OP_WRITE, 1'b1, 8'h04, 8'h00);
		push_word(usmc_pkg::OP_RECV, 1'b0, 8'h3c, 8'hff);
		push_word(usmc_pkg::OP_CLEAR, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00);
		push_word(usmc_pkg::OP_READ, 1'b0, 8'h00, 8'h00);
		drain();

		no_gaps = 1'b1;
		random_traffic(60);
		drain();
		no_gaps = 1'b0;

		set_rx_delay(16'd0);
		random_traffic(20);
		drain();

		set_rx_delay(16'd3);
		random_traffic(30);
		drain();

		set_rx_delay(16'hffff);
		stall_armed = 1'b1;
		fill_receive_buffer();
		drain();

		if (expected_q.size() != 0) begin
			$error("%0d expected result words never arrived.", expected_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/usmc_pkg.sv
design/usmc_ram.sv
design/usmc_rx_fifo.sv
design/usmc_ctrl.sv
design/usart_mode_command_rx_fifo.sv
design/usmc_checker.sv
verif/usart_mode_command_rx_fifo_tb.sv
